// ----- design/lbc_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU block cache package
// Sizes, operation codes, register addresses and stream packing widths
// shared by the cache logic and its checks.
// ----------------------------------------------------------------------------
package lbc_pkg;

	// Storage geometry.
	localparam int ENTRIES   = 8;
	localparam int DATA_BITS = 64;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int RANK_W    = $clog2(ENTRIES);
	localparam int CNT_W     = $clog2(ENTRIES + 1);

	// Field widths of the stream items.
	localparam int OP_W      = 2;
	localparam int BLOCK_W   = 32;
	localparam int WORD_W    = 64;
	localparam int COUNT_W   = 32;
	localparam int CAP_W     = 4;

	// Packed stream widths, rounded up to whole bytes.
	localparam int IN_RAW_W   = BLOCK_W + WORD_W + 1;
	localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
	localparam int OUT_RAW_W  = 1 + WORD_W + 1 + BLOCK_W + 1 + 2 * COUNT_W;
	localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

	// Configuration port.
	localparam int ADDR_W   = 3;
	localparam int PDATA_W  = 32;
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(ENTRIES);

	// Operation codes carried in the input tuser field.
	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP     = 2'd0,
		OP_INSERT     = 2'd1,
		OP_MARK_DIRTY = 2'd2,
		OP_NOP        = 2'd3
	} opcode_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] vec);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- design/lru_block_cache_top.sv -----
// ----------------------------------------------------------------------------
// LRU block cache top level
// Fully associative cache with age-rank replacement, stream in and out.
// ----------------------------------------------------------------------------
// A transaction accepted from the input stream waits in the input register;
// its result is registered in the result register when it leaves that stage.
// Throughput: one transaction per cycle while m_tready drains results; the tag
// compare, rank update and state write all complete as an item leaves the input stage.
// Reset: arst_n clears all valid, dirty and rank state, the hit and miss
// counters and the stage valids, and sets capacity to eight.
module lru_block_cache_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// tdata, lowest bit up: block[31:0], write_data[95:32], dirty_in[96], zero pad
	input  logic [lbc_pkg::IN_DATA_W-1:0]   s_tdata,
	// tuser: opcode[1:0]
	input  logic [lbc_pkg::OP_W-1:0]        s_tuser,
	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tdata, lowest bit up: hit[0], read_data[64:1], evicted[65],
	// evicted_block[97:66], evicted_dirty[98], hit_count[130:99],
	// miss_count[162:131], zero pad
	output logic [lbc_pkg::OUT_DATA_W-1:0]  m_tdata,
	// Configuration port.
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lbc_pkg::ADDR_W-1:0]      paddr,
	input  logic [lbc_pkg::PDATA_W-1:0]     pwdata,
	output logic [lbc_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready
);
	import lbc_pkg::*;

	// Configuration register.
	logic [CAP_W-1:0] cap_q;

	// Input stage.
	logic                 valid_s1;
	opcode_t              op_s1;
	logic [BLOCK_W-1:0]   block_s1;
	logic [DATA_BITS-1:0] wdata_s1;
	logic                 dirty_s1;
	logic                 adv_s1;

	// Result stage.
	logic                  res_valid_s2;
	logic [OUT_DATA_W-1:0] res_s2;

	// Cache state.
	logic [ENTRIES-1:0]   valid_q;
	logic [ENTRIES-1:0]   dirty_q;
	logic [RANK_W-1:0]    rank_q [ENTRIES];
	logic [BLOCK_W-1:0]   tag_q [ENTRIES];
	logic [DATA_BITS-1:0] payload_q [ENTRIES];
	logic [COUNT_W-1:0]   hit_q;
	logic [COUNT_W-1:0]   miss_q;

	// Next-state and lookup signals.
	logic [ENTRIES-1:0]   match_vec;
	logic [ENTRIES-1:0]   lru_vec;
	logic [ENTRIES-1:0]   free_vec;
	logic                 hit_any;
	logic [IDX_W-1:0]     hit_idx;
	logic [IDX_W-1:0]     lru_idx;
	logic [IDX_W-1:0]     free_idx;
	logic [CNT_W-1:0]     used;
	logic [CNT_W-1:0]     used_m1;
	logic [CNT_W-1:0]     cap_eff;
	logic                 need_evict;
	logic [RANK_W-1:0]    hit_rank;
	logic [ENTRIES-1:0]   valid_d;
	logic [ENTRIES-1:0]   dirty_d;
	logic [RANK_W-1:0]    rank_d [ENTRIES];
	logic [COUNT_W-1:0]   hit_d;
	logic [COUNT_W-1:0]   miss_d;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_idx;
	logic                 res_hit;
	logic [WORD_W-1:0]    res_rdata;
	logic [BLOCK_W-1:0]   res_evblk;
	logic                 res_evdirty;

	// Configuration port: writes complete in the access cycle, reads are direct.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CAPACITY) begin
			prdata = PDATA_W'(cap_q);
		end
	end

	// Handshake: the input stage moves on whenever the result stage is free or draining.
	assign adv_s1   = valid_s1 && (!res_valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign m_tvalid = res_valid_s2;
	assign m_tdata  = res_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= opcode_t'(s_tuser);
			block_s1 <= s_tdata[BLOCK_W-1:0];
			wdata_s1 <= s_tdata[BLOCK_W +: DATA_BITS];
			dirty_s1 <= s_tdata[BLOCK_W + WORD_W];
		end
	end

	// Tag compare and occupancy.
	always_comb begin
		used = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i] = valid_q[i] && (tag_q[i] == block_s1);
			used         = used + CNT_W'(valid_q[i]);
		end
	end

	assign hit_any  = |match_vec;
	assign hit_idx  = first_set(match_vec);
	assign hit_rank = rank_q[hit_idx];
	assign used_m1  = used - CNT_W'(1);

	// Effective capacity: zero acts as one, anything above the entry count is clamped.
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (32'(cap_q) > 32'(ENTRIES)) begin
			cap_eff = CNT_W'(ENTRIES);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	// Ranks among valid entries are distinct, so the LRU entry holds rank used-1.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			lru_vec[i] = valid_q[i] && (rank_q[i] == RANK_W'(used_m1));
		end
	end

	assign lru_idx    = first_set(lru_vec);
	assign need_evict = (op_s1 == OP_INSERT) && !hit_any && (used >= cap_eff);
	assign free_vec   = ~valid_q | (need_evict ? lru_vec : '0);
	assign free_idx   = first_set(free_vec);

	// Next state of valid, dirty and rank vectors and of the counters.
	always_comb begin
		valid_d = valid_q;
		dirty_d = dirty_q;
		hit_d   = hit_q;
		miss_d  = miss_q;
		mem_we  = 1'b0;
		mem_idx = hit_any ? hit_idx : free_idx;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
		end
		unique case (op_s1)
			OP_LOOKUP: begin
				if (hit_any) begin
					hit_d = hit_q + COUNT_W'(1);
					for (int i = 0; i < ENTRIES; i++) begin
						if (IDX_W'(i) != hit_idx && valid_q[i] && rank_q[i] < hit_rank) begin
							rank_d[i] = rank_q[i] + RANK_W'(1);
						end
					end
					rank_d[hit_idx] = '0;
				end else begin
					miss_d = miss_q + COUNT_W'(1);
				end
			end
			OP_INSERT: begin
				mem_we = 1'b1;
				if (hit_any) begin
					// Re-insert of a resident block: refresh it, no eviction.
					for (int i = 0; i < ENTRIES; i++) begin
						if (IDX_W'(i) != hit_idx && valid_q[i] && rank_q[i] < hit_rank) begin
							rank_d[i] = rank_q[i] + RANK_W'(1);
						end
					end
					rank_d[hit_idx]  = '0;
					dirty_d[hit_idx] = dirty_s1;
				end else begin
					if (need_evict) begin
						valid_d[lru_idx] = 1'b0;
						dirty_d[lru_idx] = 1'b0;
					end
					// Every surviving entry ages by one, the new one is most recent.
					for (int i = 0; i < ENTRIES; i++) begin
						if (valid_d[i]) begin
							rank_d[i] = rank_q[i] + RANK_W'(1);
						end
					end
					valid_d[free_idx] = 1'b1;
					dirty_d[free_idx] = dirty_s1;
					rank_d[free_idx]  = '0;
				end
			end
			OP_MARK_DIRTY: begin
				if (hit_any) begin
					dirty_d[hit_idx] = 1'b1;
				end
			end
			OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	// Control state of the cache.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			hit_q   <= '0;
			miss_q  <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (adv_s1) begin
			valid_q <= valid_d;
			dirty_q <= dirty_d;
			hit_q   <= hit_d;
			miss_q  <= miss_d;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

	// Tag and payload storage, written on every insert.
	always_ff @(posedge clk) begin
		if (adv_s1 && mem_we) begin
			tag_q[mem_idx]     <= block_s1;
			payload_q[mem_idx] <= wdata_s1;
		end
	end

	// Result fields; meaningless fields are zero.
	assign res_hit     = (op_s1 == OP_LOOKUP) && hit_any;
	assign res_rdata   = res_hit ? WORD_W'(payload_q[hit_idx]) : '0;
	assign res_evblk   = need_evict ? tag_q[lru_idx] : '0;
	assign res_evdirty = need_evict && dirty_q[lru_idx];

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			res_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= OUT_DATA_W'({miss_d, hit_d, res_evdirty, res_evblk, need_evict,
				res_rdata, res_hit});
		end
	end

`ifndef ASSERT_OFF
	// A tag is never resident in two entries.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(match_vec))
		else $error("block matches more than one valid entry");

	// An insert that must evict always finds exactly one LRU entry.
	a_lru_found: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && need_evict) |-> $onehot(lru_vec))
		else $error("no unique least recently used entry at eviction");

	// Each lookup moves exactly one of the two counters by one.
	a_lookup_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && op_s1 == OP_LOOKUP) |=>
		(32'(hit_q + miss_q) == 32'($past(hit_q) + $past(miss_q) + 32'd1)))
		else $error("lookup counters out of step");

	// An item leaving the input stage yields a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> res_valid_s2)
		else $error("result register not loaded");
`endif

endmodule

// ----- verif/lbc_checker.sv -----
// ----------------------------------------------------------------------------
// LRU block cache checker
// Watches the input stream, the result stream and the configuration port of
// the cache. It keeps its own copy of the tag store, the age ranks, the
// counters and the capacity setting, works out the reply to each accepted
// transaction, and compares every returned reply field by field with the
// oldest reply still due.
// ----------------------------------------------------------------------------
module lbc_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// tdata, lowest bit up: block, write_data, dirty_in, zero pad
	input  logic [lbc_pkg::IN_DATA_W-1:0]   s_tdata,
	// tuser: opcode
	input  logic [lbc_pkg::OP_W-1:0]        s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// tdata, lowest bit up: hit, read_data, evicted, evicted_block,
	// evicted_dirty, hit_count, miss_count, zero pad
	input  logic [lbc_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [lbc_pkg::ADDR_W-1:0]      paddr,
	input  logic [lbc_pkg::PDATA_W-1:0]     pwdata,
	output int                              fail_count,
	output int                              pending
);
	import lbc_pkg::*;

	localparam logic [ADDR_W-1:0] CAP_ADDR  = ADDR_W'(4 * REG_CAPACITY);
	localparam logic [WORD_W-1:0] WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - DATA_BITS);

	// One reply, laid out so that the first field sits in the lowest bits.
	typedef struct packed {
		logic [COUNT_W-1:0] miss_count;
		logic [COUNT_W-1:0] hit_count;
		logic               evicted_dirty;
		logic [BLOCK_W-1:0] evicted_block;
		logic               evicted;
		logic [WORD_W-1:0]  read_data;
		logic               hit;
	} cache_reply_t;

	// Shadow copy of the cache contents and settings.
	logic               line_valid [ENTRIES];
	logic [BLOCK_W-1:0] line_tag   [ENTRIES];
	logic [WORD_W-1:0]  line_word  [ENTRIES];
	logic               line_dirty [ENTRIES];
	logic [RANK_W-1:0]  line_age   [ENTRIES];
	logic [COUNT_W-1:0] hits_seen;
	logic [COUNT_W-1:0] misses_seen;
	logic [CAP_W-1:0]   cap_setting;

	cache_reply_t replies_due [$];

	// Make one line the most recent; lines that were newer age by one.
	function automatic void promote_line(input int idx);
		logic [RANK_W-1:0] old_age;
		old_age = line_age[idx];
		for (int i = 0; i < ENTRIES; i++) begin
			if (i != idx && line_valid[i] && line_age[i] < old_age) begin
				line_age[i]++;
			end
		end
		line_age[idx] = '0;
	endfunction

	// Apply one operation to the shadow cache and return the reply it causes.
	function automatic cache_reply_t apply_cache_op(input opcode_t op,
			input logic [BLOCK_W-1:0] blk, input logic [WORD_W-1:0] word,
			input logic dflag);
		cache_reply_t rep;
		int idx;
		int limit;
		int used;
		int victim;
		int slot;
		rep = '0;
		idx = -1;
		for (int i = 0; i < ENTRIES; i++) begin
			if (idx < 0 && line_valid[i] && line_tag[i] == blk) begin
				idx = i;
			end
		end
		case (op)
			OP_LOOKUP: begin
				if (idx >= 0) begin
					promote_line(idx);
					rep.hit       = 1'b1;
					rep.read_data = line_word[idx] & WORD_MASK;
					hits_seen++;
				end else begin
					misses_seen++;
				end
			end
			OP_INSERT: begin
				if (idx < 0) begin
					// Out-of-range capacity settings clamp to 1..ENTRIES.
					limit = int'(cap_setting);
					if (limit < 1) begin
						limit = 1;
					end
					if (limit > ENTRIES) begin
						limit = ENTRIES;
					end
					used = 0;
					for (int i = 0; i < ENTRIES; i++) begin
						if (line_valid[i]) begin
							used++;
						end
					end
					// At most one line leaves per insert, the oldest one.
					if (used >= limit) begin
						victim = -1;
						for (int i = 0; i < ENTRIES; i++) begin
							if (line_valid[i] &&
									(victim < 0 || line_age[i] > line_age[victim])) begin
								victim = i;
							end
						end
						if (victim >= 0) begin
							rep.evicted       = 1'b1;
							rep.evicted_block = line_tag[victim];
							rep.evicted_dirty = line_dirty[victim];
							line_valid[victim] = 1'b0;
							line_dirty[victim] = 1'b0;
						end
					end
					// The new block takes the lowest free line.
					slot = -1;
					for (int i = 0; i < ENTRIES; i++) begin
						if (slot < 0 && !line_valid[i]) begin
							slot = i;
						end
					end
					if (slot >= 0) begin
						for (int i = 0; i < ENTRIES; i++) begin
							if (line_valid[i]) begin
								line_age[i]++;
							end
						end
						line_valid[slot] = 1'b1;
						line_tag[slot]   = blk;
						line_age[slot]   = '0;
						idx = slot;
					end
				end else begin
					// A resident block is overwritten in place.
					promote_line(idx);
				end
				if (idx >= 0) begin
					line_word[idx]  = word & WORD_MASK;
					line_dirty[idx] = dflag;
				end
			end
			OP_MARK_DIRTY: begin
				if (idx >= 0) begin
					line_dirty[idx] = 1'b1;
				end
			end
			default: begin
			end
		endcase
		rep.hit_count  = hits_seen;
		rep.miss_count = misses_seen;
		return rep;
	endfunction

	task automatic compare_field(input string label, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", label, want, got);
			fail_count++;
		end
	endtask

	// Compare returned replies, then follow register writes and new requests.
	always @(posedge clk or negedge arst_n) begin
		cache_reply_t want;
		cache_reply_t got;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				line_valid[i] = 1'b0;
				line_tag[i]   = '0;
				line_word[i]  = '0;
				line_dirty[i] = 1'b0;
				line_age[i]   = '0;
			end
			hits_seen   = '0;
			misses_seen = '0;
			cap_setting = CAPACITY_RESET;
			replies_due.delete();
			fail_count  = 0;
			pending     = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = cache_reply_t'(m_tdata[OUT_RAW_W-1:0]);
				if (replies_due.size() == 0) begin
					$error("reply transaction arrived with none due: %0h", got);
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					compare_field("hit", want.hit, got.hit);
					compare_field("read_data", want.read_data, got.read_data);
					compare_field("evicted", want.evicted, got.evicted);
					compare_field("evicted_block", want.evicted_block, got.evicted_block);
					compare_field("evicted_dirty", want.evicted_dirty, got.evicted_dirty);
					compare_field("hit_count", want.hit_count, got.hit_count);
					compare_field("miss_count", want.miss_count, got.miss_count);
				end
			end
			if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
				cap_setting = pwdata[CAP_W-1:0];
			end
			if (s_tvalid && s_tready) begin
				replies_due.push_back(apply_cache_op(opcode_t'(s_tuser),
					s_tdata[BLOCK_W-1:0], s_tdata[BLOCK_W +: WORD_W],
					s_tdata[BLOCK_W + WORD_W]));
			end
			pending = replies_due.size();
		end
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// LRU block cache testbench
// Drives lookups, inserts and mark-dirty requests into the cache under a
// series of capacity settings, with random gaps on the request side and
// random stalls on the reply side. A checker beside the cache predicts and
// compares every reply; this module makes the traffic and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import lbc_pkg::*;

	localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'(4 * REG_CAPACITY);
	localparam int PHASES         = 12;
	localparam int ITEMS_PER_PHASE = 153;
	localparam int HOLD_CYCLES    = 120;
	localparam int QUIET_LIMIT    = 4000;
	localparam int SETTLE_CYCLES  = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [OP_W-1:0]       s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b1;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [ADDR_W-1:0]     paddr = '0;
	logic [PDATA_W-1:0]    pwdata = '0;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;

	int fail_count;
	int pending;

	bit sender_idle_en   = 1'b0;
	bit receiver_idle_en = 1'b0;
	bit hold_req         = 1'b0;

	logic [CAP_W-1:0]   cap_plan [PHASES];
	logic [BLOCK_W-1:0] tag_pool [16];
	int                 pool_size;

	lru_block_cache_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	lbc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Offer one request and hold it until the cache takes it. Valid stays
	// high afterwards unless the next request is preceded by a gap.
	task automatic send_request(input opcode_t op, input logic [BLOCK_W-1:0] blk,
			input logic [WORD_W-1:0] word, input logic dflag);
		if (sender_idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_DATA_W'({dflag, word, blk});
		do @(posedge clk); while (!s_tready);
	endtask

	// Wait until every reply due has come back.
	task automatic drain_replies();
		do @(posedge clk); while (pending != 0);
	endtask

	// Two-phase register write; the register takes the value at the access edge.
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAP_ADDR;
		pwdata  <= PDATA_W'(cap);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Reply side: random stalls, and one long hold-off on request.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (receiver_idle_en && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("lru_block_cache_top regression: fail");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		int pick;
		opcode_t op;
		logic [BLOCK_W-1:0] blk;
		cap_plan = '{4'd15, 4'd1, 4'd4, 4'd8, 4'd0, 4'd2, 4'd9, 4'd6, 4'd3, 4'd7,
			4'd5, 4'd8};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at capacity two: misses, hits, eviction of dirty lines,
		// re-insert, mark dirty of present and absent blocks.
		write_capacity(4'd2);
		send_request(OP_LOOKUP, 32'h0000_0000, '0, 1'b0);
		send_request(OP_INSERT, 32'h0000_0000, '0, 1'b1);
		send_request(OP_INSERT, 32'hFFFF_FFFF, '1, 1'b0);
		send_request(OP_LOOKUP, 32'h0000_0000, '1, 1'b1);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, '0, 1'b0);
		send_request(OP_INSERT, 32'h0000_0005, 64'h5555_5555_5555_5555, 1'b0);
		send_request(OP_MARK_DIRTY, 32'hFFFF_FFFF, '0, 1'b0);
		send_request(OP_MARK_DIRTY, 32'h0000_0000, '1, 1'b1);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, '0, 1'b0);
		send_request(OP_INSERT, 32'h0000_0005, 64'h0123_4567_89AB_CDEF, 1'b0);
		send_request(OP_INSERT, 32'h0000_0007, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
		send_request(OP_NOP, 32'hFFFF_FFFF, '1, 1'b1);
		send_request(OP_LOOKUP, 32'h0000_0005, '0, 1'b0);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 64'hDEAD_BEEF_0000_FFFF, 1'b1);
		send_request(OP_LOOKUP, 32'h0000_0007, '0, 1'b0);
		s_tvalid <= 1'b0;
		drain_replies();

		// Capacity zero behaves as one, with two lines still resident.
		write_capacity(4'd0);
		send_request(OP_INSERT, 32'h0000_0003, 64'h1, 1'b0);
		send_request(OP_INSERT, 32'h0000_0004, 64'h2, 1'b1);
		send_request(OP_LOOKUP, 32'h0000_0003, '0, 1'b0);
		send_request(OP_LOOKUP, 32'h0000_0004, '0, 1'b0);
		s_tvalid <= 1'b0;
		drain_replies();

		// Random phases, each under its own capacity; the last runs without gaps.
		for (int p = 0; p < PHASES; p++) begin
			write_capacity(cap_plan[p]);
			sender_idle_en   = (p != PHASES - 1) && (p != 3) && ($urandom_range(0, 3) != 0);
			receiver_idle_en = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
			if (p == 3) begin
				hold_req = 1'b1;
			end
			pool_size = $urandom_range(2, 16);
			for (int k = 0; k < pool_size; k++) begin
				tag_pool[k] = $urandom;
			end
			tag_pool[0] = $urandom_range(0, 1) ? '0 : '1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					op = OP_LOOKUP;
				end else if (pick < 80) begin
					op = OP_INSERT;
				end else if (pick < 93) begin
					op = OP_MARK_DIRTY;
				end else begin
					op = OP_NOP;
				end
				if ($urandom_range(0, 99) < 85) begin
					blk = tag_pool[$urandom_range(0, pool_size - 1)];
				end else begin
					blk = $urandom;
				end
				send_request(op, blk, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
			end
			s_tvalid <= 1'b0;
			drain_replies();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("lru_block_cache_top regression: pass");
		end else begin
			$display("lru_block_cache_top regression: fail");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/lbc_pkg.sv
design/lru_block_cache_top.sv
verif/lbc_checker.sv
verif/tb.sv
